>>> src/aat_pkg.sv
package aat_pkg;

   localparam int AXES       = 3;
   localparam int COORD_W    = 16;
   localparam int ROW_W      = 64;
   localparam int PROD_W     = 2 * COORD_W;
   localparam int SUM_W      = PROD_W + 2;
   localparam int FRAC_SHIFT = 12;
   localparam int SHIFT_W    = SUM_W - FRAC_SHIFT;

   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [PROD_W-1:0]  prod_word_type;
   typedef logic [SUM_W-1:0]   sum_word_type;

   // products of one matrix row with the low and high box coordinates
   typedef struct packed {
      prod_word_type [AXES-1:0] lo;
      prod_word_type [AXES-1:0] hi;
      coord_type                trans;
   } prod_type;

   // per-term extremes of one row
   typedef struct packed {
      prod_word_type [AXES-1:0] mn;
      prod_word_type [AXES-1:0] mx;
      coord_type                trans;
   } pick_type;

   typedef struct packed {
      sum_word_type mn;
      sum_word_type mx;
   } sum_type;

   typedef struct packed {
      coord_type [AXES-1:0] mn;
      coord_type [AXES-1:0] mx;
   } bound_type;

   function automatic prod_word_type mul_s16(input coord_type a, input coord_type b);
      logic signed [PROD_W-1:0] ae;
      logic signed [PROD_W-1:0] be;
      logic signed [PROD_W-1:0] p;
      ae = {{COORD_W{a[COORD_W-1]}}, a};
      be = {{COORD_W{b[COORD_W-1]}}, b};
      p  = ae * be;
      return p;
   endfunction

   function automatic sum_word_type ext_prod(input prod_word_type p);
      return {{(SUM_W-PROD_W){p[PROD_W-1]}}, p};
   endfunction

   // Q8.8 translation lined up with the Q.20 products
   function automatic sum_word_type ext_trans(input coord_type t);
      return {{(SUM_W-COORD_W-FRAC_SHIFT){t[COORD_W-1]}}, t, {FRAC_SHIFT{1'b0}}};
   endfunction

   // floor shift back to Q8.8, then saturate to 16 bits
   function automatic coord_type shift_sat(input sum_word_type s);
      logic signed [SHIFT_W-1:0] q;
      logic signed [SHIFT_W-1:0] hi_lim;
      logic signed [SHIFT_W-1:0] lo_lim;
      coord_type                 r;
      q      = s[SUM_W-1:FRAC_SHIFT];
      hi_lim = {{(SHIFT_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
      lo_lim = {{(SHIFT_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};
      if (q > hi_lim) begin
         r = {1'b0, {(COORD_W-1){1'b1}}};
      end else if (q < lo_lim) begin
         r = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         r = q[COORD_W-1:0];
      end
      return r;
   endfunction

endpackage

>>> src/aat_mult.sv
module aat_mult
   import aat_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        valid_in,
   input  logic [AXES-1:0][ROW_W-1:0]  row,
   input  coord_type [AXES-1:0]        box_lo,
   input  coord_type [AXES-1:0]        box_hi,
   output logic                        valid_out,
   output prod_type [AXES-1:0]         prod_out
);

   logic                valid_ff;
   prod_type [AXES-1:0] prod_ff;
   prod_type [AXES-1:0] prod_in;

   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         for (int j = 0; j < AXES; j++) begin
            prod_in[a].lo[j] = mul_s16(row[a][COORD_W*j +: COORD_W], box_lo[j]);
            prod_in[a].hi[j] = mul_s16(row[a][COORD_W*j +: COORD_W], box_hi[j]);
         end
         prod_in[a].trans = row[a][COORD_W*AXES +: COORD_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      prod_ff <= prod_in;
   end

   assign valid_out = valid_ff;
   assign prod_out  = prod_ff;

endmodule

>>> src/aat_bound.sv
module aat_bound
   import aat_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                valid_in,
   input  prod_type [AXES-1:0] prod_in,
   output logic                valid_out,
   output sum_type [AXES-1:0]  sum_out
);

   // The sum is separable: the extreme corner takes the extreme of each term.
   logic                pick_valid_ff;
   pick_type [AXES-1:0] pick_ff;
   pick_type [AXES-1:0] pick_in;
   logic                sum_valid_ff;
   sum_type [AXES-1:0]  sum_ff;
   sum_type [AXES-1:0]  sum_in;

   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         for (int j = 0; j < AXES; j++) begin
            if ($signed(prod_in[a].lo[j]) < $signed(prod_in[a].hi[j])) begin
               pick_in[a].mn[j] = prod_in[a].lo[j];
               pick_in[a].mx[j] = prod_in[a].hi[j];
            end else begin
               pick_in[a].mn[j] = prod_in[a].hi[j];
               pick_in[a].mx[j] = prod_in[a].lo[j];
            end
         end
         pick_in[a].trans = prod_in[a].trans;
      end
   end

   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         sum_in[a].mn = ext_trans(pick_ff[a].trans) + ext_prod(pick_ff[a].mn[0])
                      + ext_prod(pick_ff[a].mn[1]) + ext_prod(pick_ff[a].mn[2]);
         sum_in[a].mx = ext_trans(pick_ff[a].trans) + ext_prod(pick_ff[a].mx[0])
                      + ext_prod(pick_ff[a].mx[1]) + ext_prod(pick_ff[a].mx[2]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pick_valid_ff <= 1'b0;
         sum_valid_ff  <= 1'b0;
      end else begin
         pick_valid_ff <= valid_in;
         sum_valid_ff  <= pick_valid_ff;
      end
      pick_ff <= pick_in;
      sum_ff  <= sum_in;
   end

   assign valid_out = sum_valid_ff;
   assign sum_out   = sum_ff;

endmodule

>>> src/aat_clamp.sv
module aat_clamp
   import aat_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               valid_in,
   input  sum_type [AXES-1:0] sum_in,
   output logic               valid_out,
   output bound_type          bound_out
);

   logic      valid_ff;
   bound_type bound_ff;
   bound_type bound_in;

   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         bound_in.mn[a] = shift_sat(sum_in[a].mn);
         bound_in.mx[a] = shift_sat(sum_in[a].mx);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      bound_ff <= bound_in;
   end

   assign valid_out = valid_ff;
   assign bound_out = bound_ff;

endmodule

>>> src/aabb_affine_transform.sv
// Transformed axis-aligned box bounds.
//
// Request: drive req_row_x/y/z (three Q4.12 coefficients low to high, then a
// Q8.8 translation) and the source box corners, and pulse start. A beat is
// taken at each rising edge with start high and busy low. busy stays low, so
// a new box may be issued on every cycle.
//
// Response: rsp_valid is high for one cycle with the new box on the rsp_out_*
// ports, after the request has passed the pipeline registers. One result per
// request, in request order. Throughput is one box per cycle, set by the
// four-stage pipeline: multiply, per-term min/max pick, row sum, floor shift
// and saturate.
//
// The receiver cannot stall; every response beat is taken as it appears.
// Synchronous reset clears the valid pipeline, dropping any boxes in flight.
module aabb_affine_transform
   import aat_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [ROW_W-1:0]         req_row_x,
   input  logic [ROW_W-1:0]         req_row_y,
   input  logic [ROW_W-1:0]         req_row_z,
   input  logic signed [COORD_W-1:0] req_box_min_x,
   input  logic signed [COORD_W-1:0] req_box_min_y,
   input  logic signed [COORD_W-1:0] req_box_min_z,
   input  logic signed [COORD_W-1:0] req_box_max_x,
   input  logic signed [COORD_W-1:0] req_box_max_y,
   input  logic signed [COORD_W-1:0] req_box_max_z,
   output logic                     rsp_valid,
   output logic signed [COORD_W-1:0] rsp_out_min_x,
   output logic signed [COORD_W-1:0] rsp_out_min_y,
   output logic signed [COORD_W-1:0] rsp_out_min_z,
   output logic signed [COORD_W-1:0] rsp_out_max_x,
   output logic signed [COORD_W-1:0] rsp_out_max_y,
   output logic signed [COORD_W-1:0] rsp_out_max_z
);

   logic [AXES-1:0][ROW_W-1:0] rows;
   coord_type [AXES-1:0]       box_lo;
   coord_type [AXES-1:0]       box_hi;
   logic                       accept;
   logic                       prod_valid;
   prod_type [AXES-1:0]        prod;
   logic                       sum_valid;
   sum_type [AXES-1:0]         sums;
   bound_type                  bound;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign rows   = {req_row_z, req_row_y, req_row_x};
   assign box_lo = {req_box_min_z, req_box_min_y, req_box_min_x};
   assign box_hi = {req_box_max_z, req_box_max_y, req_box_max_x};

   aat_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (accept),
      .row       (rows),
      .box_lo    (box_lo),
      .box_hi    (box_hi),
      .valid_out (prod_valid),
      .prod_out  (prod)
   );

   aat_bound u_bound (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (prod_valid),
      .prod_in   (prod),
      .valid_out (sum_valid),
      .sum_out   (sums)
   );

   aat_clamp u_clamp (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (sum_valid),
      .sum_in    (sums),
      .valid_out (rsp_valid),
      .bound_out (bound)
   );

   assign rsp_out_min_x = bound.mn[0];
   assign rsp_out_min_y = bound.mn[1];
   assign rsp_out_min_z = bound.mn[2];
   assign rsp_out_max_x = bound.mx[0];
   assign rsp_out_max_y = bound.mx[1];
   assign rsp_out_max_z = bound.mx[2];

   // every accepted beat comes out as a response
   a_latency : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##4 rsp_valid)
      else $error("response missing four cycles after request");

   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 4))
      else $error("response without a matching request");

   // per-term picks make the bounds ordered even for an inverted source box
   a_ordered : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_min_x <= rsp_out_max_x) && (rsp_out_min_y <= rsp_out_max_y)
                    && (rsp_out_min_z <= rsp_out_max_z))
      else $error("transformed box minimum above maximum");

endmodule
